/* hdl/slcfp_pkg.sv */
// shared types and constants of the sync/length/checksum frame parser
// no dependencies; used by every module of the block and by the checker
`timescale 1ns / 1ps

package slcfp_pkg;

	localparam int MAX_PAYLOAD = 62;
	localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
	localparam int LEN_W       = $clog2(MAX_PAYLOAD + 2);

	localparam logic [7:0] SYNC_BYTE = 8'h55;
	localparam logic [7:0] MAX_LEN   = 8'(MAX_PAYLOAD);

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_CSUM = 2'd1,
		ST_CMD  = 2'd2,
		ST_LONG = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_HUNT = 3'b001,
		PH_LEN  = 3'b010,
		PH_PAY  = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE  = 2'b01,
		BK_FRAME = 2'b10
	} back_state_t;

	// one unit of work for the back end: a status result or a frame to replay
	typedef struct packed {
		status_t           status;
		logic [7:0]        data;
		logic [LEN_W-1:0]  len;
	} job_t;

	// payload store write port driven by the front end
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} mem_wr_t;

	function automatic logic is_known_cmd(input logic [7:0] c);
		logic known;
		unique case (c) inside
			8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h10, 8'h20: known = 1'b1;
			default: known = 1'b0;
		endcase
		return known;
	endfunction

endpackage

/* hdl/slcfp_queue.sv */
// two-entry job queue between the front and back ends
// depends on slcfp_pkg
`timescale 1ns / 1ps

module slcfp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  slcfp_pkg::job_t push_job,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output slcfp_pkg::job_t head
);

	slcfp_pkg::job_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hdl/slcfp_front.sv */
// front end: accepts input transfers, tracks framing, checksum and command,
// writes the payload store and posts jobs; depends on slcfp_pkg
`timescale 1ns / 1ps

module slcfp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] in_byte
	input  logic              s_tuser,   // [0] op
	input  logic              q_full,
	input  logic              frame_done,
	output logic              push,
	output slcfp_pkg::job_t   push_job,
	output slcfp_pkg::mem_wr_t mem_wr
);

	slcfp_pkg::phase_t                phase_q, phase_d;
	logic [slcfp_pkg::LEN_W-1:0]      len_q, len_d;
	logic [slcfp_pkg::ADDR_W-1:0]     seen_q, seen_d;
	logic [7:0]                       sum_q, sum_d;
	logic [7:0]                       cmd_q, cmd_d;
	logic                             pend_q;
	logic                             accept;
	logic [slcfp_pkg::LEN_W:0]        seen_inc;
	logic [7:0]                       cmd_now;

	// a replayed frame still reads the store, so hold off until it is done
	assign s_tready = !q_full && !pend_q;
	assign accept   = s_tvalid && s_tready;
	assign seen_inc = (slcfp_pkg::LEN_W + 1)'(seen_q) + 1'b1;
	assign cmd_now  = (seen_q == '0) ? s_tdata : cmd_q;

	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		seen_d   = seen_q;
		sum_d    = sum_q;
		cmd_d    = cmd_q;
		push     = 1'b0;
		push_job = '0;
		mem_wr   = '0;
		if (accept) begin
			if (s_tuser) begin
				phase_d = slcfp_pkg::PH_HUNT;
			end else begin
				unique case (phase_q)
					slcfp_pkg::PH_LEN: begin
						if (s_tdata == 8'h00) begin
							phase_d = slcfp_pkg::PH_HUNT;
						end else if (s_tdata > slcfp_pkg::MAX_LEN) begin
							push            = 1'b1;
							push_job.status = slcfp_pkg::ST_LONG;
							push_job.data   = s_tdata;
							phase_d         = slcfp_pkg::PH_HUNT;
						end else begin
							len_d   = s_tdata[slcfp_pkg::LEN_W-1:0];
							seen_d  = '0;
							sum_d   = 8'h00;
							phase_d = slcfp_pkg::PH_PAY;
						end
					end
					slcfp_pkg::PH_PAY: begin
						mem_wr.en   = 1'b1;
						mem_wr.addr = seen_q;
						mem_wr.data = s_tdata;
						if (seen_q == '0) begin
							cmd_d = s_tdata;
						end
						if (seen_inc == (slcfp_pkg::LEN_W + 1)'(len_q)) begin
							push    = 1'b1;
							phase_d = slcfp_pkg::PH_HUNT;
							if (s_tdata != sum_q) begin
								push_job.status = slcfp_pkg::ST_CSUM;
								push_job.data   = s_tdata;
							end else if (!slcfp_pkg::is_known_cmd(cmd_now)) begin
								push_job.status = slcfp_pkg::ST_CMD;
								push_job.data   = cmd_now;
							end else begin
								push_job.status = slcfp_pkg::ST_OK;
								push_job.len    = len_q;
							end
						end else begin
							seen_d = seen_inc[slcfp_pkg::ADDR_W-1:0];
							sum_d  = sum_q + s_tdata;
						end
					end
					default: begin
						phase_d = (s_tdata == slcfp_pkg::SYNC_BYTE) ?
							slcfp_pkg::PH_LEN : slcfp_pkg::PH_HUNT;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= slcfp_pkg::PH_HUNT;
			len_q   <= '0;
			seen_q  <= '0;
			sum_q   <= 8'h00;
			pend_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			len_q   <= len_d;
			seen_q  <= seen_d;
			sum_q   <= sum_d;
			if (push && push_job.status == slcfp_pkg::ST_OK) begin
				pend_q <= 1'b1;
			end else if (frame_done) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
	end

endmodule

/* hdl/slcfp_back.sv */
// back end: holds the payload store, replays good frames byte by byte or
// emits a status result, through a read stage and an output register
// depends on slcfp_pkg
`timescale 1ns / 1ps

module slcfp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  slcfp_pkg::mem_wr_t mem_wr,
	input  logic               q_valid,
	input  slcfp_pkg::job_t    q_head,
	output logic               pop,
	output logic               frame_done,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,   // [7:0] out_byte
	output logic               m_tlast,
	output logic [1:0]         m_tuser    // [1:0] status
);

	logic [7:0] store [slcfp_pkg::MAX_PAYLOAD];

	slcfp_pkg::back_state_t        state_q;
	logic [slcfp_pkg::LEN_W-1:0]   cnt_q;
	logic [slcfp_pkg::LEN_W-1:0]   len_q;

	// read stage
	logic                          valid_s1;
	logic                          from_mem_s1;
	logic [7:0]                    byte_s1;
	logic [7:0]                    rd_data_s1;
	logic                          last_s1;
	slcfp_pkg::status_t            status_s1;

	// output register
	logic                          out_valid_q;
	logic [7:0]                    out_byte_q;
	logic                          out_last_q;
	slcfp_pkg::status_t            out_status_q;

	logic                          out_free;
	logic                          s1_move;
	logic                          s1_free;
	logic                          issue;
	logic                          iss_mem;
	logic                          iss_last;
	logic [7:0]                    iss_byte;
	slcfp_pkg::status_t            iss_status;
	logic [slcfp_pkg::ADDR_W-1:0]  rd_addr;
	logic [slcfp_pkg::LEN_W-1:0]   cnt_dec;

	assign out_free = !out_valid_q || m_tready;
	assign s1_move  = valid_s1 && out_free;
	assign s1_free  = !valid_s1 || s1_move;
	assign cnt_dec  = cnt_q - 1'b1;
	assign rd_addr  = slcfp_pkg::ADDR_W'(cnt_q - 2'd2);

	always_comb begin
		issue      = 1'b0;
		pop        = 1'b0;
		frame_done = 1'b0;
		iss_mem    = 1'b0;
		iss_last   = 1'b0;
		iss_byte   = 8'h00;
		iss_status = slcfp_pkg::ST_OK;
		if (s1_free) begin
			unique case (state_q)
				slcfp_pkg::BK_FRAME: begin
					issue = 1'b1;
					if (cnt_q == slcfp_pkg::LEN_W'(1)) begin
						iss_byte = 8'(len_q);
					end else begin
						iss_mem  = 1'b1;
						// payload index cnt-2 is the last when it equals len-1
						iss_last = (cnt_dec == len_q);
					end
					frame_done = iss_last;
				end
				default: begin
					if (q_valid) begin
						issue      = 1'b1;
						pop        = 1'b1;
						iss_status = q_head.status;
						if (q_head.status == slcfp_pkg::ST_OK) begin
							iss_byte = slcfp_pkg::SYNC_BYTE;
						end else begin
							iss_byte = q_head.data;
							iss_last = 1'b1;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			store[mem_wr.addr] <= mem_wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue && iss_mem) begin
			rd_data_s1 <= store[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= slcfp_pkg::BK_IDLE;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				if (state_q == slcfp_pkg::BK_FRAME) begin
					if (iss_last) begin
						state_q <= slcfp_pkg::BK_IDLE;
					end
				end else if (q_head.status == slcfp_pkg::ST_OK) begin
					state_q <= slcfp_pkg::BK_FRAME;
				end
			end
			if (s1_free) begin
				valid_s1 <= issue;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			from_mem_s1 <= iss_mem;
			byte_s1     <= iss_byte;
			last_s1     <= iss_last;
			status_s1   <= iss_status;
			if (state_q == slcfp_pkg::BK_FRAME) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= slcfp_pkg::LEN_W'(1);
				len_q <= q_head.len;
			end
		end
		if (s1_move) begin
			out_byte_q   <= from_mem_s1 ? rd_data_s1 : byte_s1;
			out_last_q   <= last_s1;
			out_status_q <= status_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_status_q;

endmodule

/* hdl/sync_length_checksum_frame_parser.sv */
// path: a frame's first result passes the queue, read stage and output register
// throughput: one input transfer per cycle while the queue has room and no good
// frame is being replayed; a good frame of n payload bytes emits n+2 results at
// one per cycle unless stalled, and input is held off until its last store read
// reset: arst_n clears framing state, queue and output valid; the store is not cleared
// top level: front end, job queue and back end; depends on slcfp_pkg
`timescale 1ns / 1ps

module sync_length_checksum_frame_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tuser,   // [0] op
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,
	output logic [1:0] m_tuser    // [1:0] status
);

	logic               q_full;
	logic               q_valid;
	logic               push;
	logic               pop;
	logic               frame_done;
	slcfp_pkg::job_t    push_job;
	slcfp_pkg::job_t    q_head;
	slcfp_pkg::mem_wr_t mem_wr;

	slcfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_full     (q_full),
		.frame_done (frame_done),
		.push       (push),
		.push_job   (push_job),
		.mem_wr     (mem_wr)
	);

	slcfp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	slcfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mem_wr     (mem_wr),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.pop        (pop),
		.frame_done (frame_done),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

/* hdl/slcfp_checker.sv */
// port-level checks for the frame parser, bound to the top level
// depends on slcfp_pkg
`timescale 1ns / 1ps

module slcfp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [1:0] m_tuser
);

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// status results stand alone
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != 2'(slcfp_pkg::ST_OK) |-> m_tlast)
		else $error("status result without last");

	// too-long report carries a length above the store size
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == 2'(slcfp_pkg::ST_LONG) |-> m_tdata > slcfp_pkg::MAX_LEN)
		else $error("length report with a legal length");

	// unknown-command report never carries a known command
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == 2'(slcfp_pkg::ST_CMD) |-> !slcfp_pkg::is_known_cmd(m_tdata))
		else $error("command report with a known command");

endmodule

bind sync_length_checksum_frame_parser slcfp_checker u_chk (.*);
